// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the controller and the datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property on every rising clock edge outside reset.
`define CCC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ccc assertion failed");

// Checks that a condition in one cycle is followed by another in the next.
`define CCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ccc assertion failed");

`else

`define CCC_ASSERT(lbl, clk, rst_n, prop)
`define CCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/ccc_pkg.sv =====
`default_nettype none

package ccc_pkg;

    // Default sizes of the stores and the coordinate format.
    localparam int MAX_CENTERS_DEF = 1024;
    localparam int MAX_CATIONS_DEF = 1024;
    localparam int COORD_BITS_DEF  = 22;

    // Fixed field widths.
    localparam int COUNT_W     = 11;
    localparam int RADIUS_W    = 16;
    localparam int LIM_W       = RADIUS_W + 1;
    localparam int SQ_W        = 2 * LIM_W;
    localparam int SUM_W       = SQ_W + 2;
    localparam int OUT_TDATA_W = 40;

    localparam logic [RADIUS_W-1:0] RADIUS_RST = 16'd896;

    // Register port layout.
    localparam int   CFG_ADDR_W     = 3;
    localparam int   CFG_DATA_W     = 32;
    localparam logic REG_CUTOFF_IDX = 1'b0;

    typedef enum logic [1:0] {
        KIND_OTHER  = 2'd0,
        KIND_START  = 2'd1,
        KIND_END    = 2'd2,
        KIND_CATION = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_LOAD_CAT,
        S_SCAN,
        S_DRAIN,
        S_FINISH,
        S_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic walk_start;
        logic cat_rd;
        logic cen_rd;
        logic cat_next;
        logic result_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic no_work;
        logic cat_last;
        logic cen_last;
        logic pipe_busy;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== sv/cutoff_contact_counter_core.sv =====
// After the last record the result appears once the pairwise walk is done (no walk when
// either store is empty). Throughput: one record per cycle while loading; the pairwise walk
// reads one center per cycle from the center store and drains the distance pipeline after
// each cation, then gives one result.
// Reset: synchronous, active low; clears counts, the drop flag and the pending start
// position, and loads the cutoff radius with 896. Stores are not cleared.
`default_nettype none

module cutoff_contact_counter_core #(
    parameter int MAX_CENTERS = ccc_pkg::MAX_CENTERS_DEF,
    parameter int MAX_CATIONS = ccc_pkg::MAX_CATIONS_DEF,
    parameter int COORD_BITS  = ccc_pkg::COORD_BITS_DEF,
    localparam int IN_TDATA_W = ((3 * COORD_BITS + 7) / 8) * 8
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // Record stream.
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // pos_x, pos_y, pos_z from the lowest bit up, zero padded.
    input  wire logic [IN_TDATA_W-1:0]                s_axis_tdata,
    // atom_kind.
    input  wire logic [1:0]                           s_axis_tuser,
    input  wire logic                                 s_axis_tlast,
    // Result stream.
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // center_count, cation_count, contact_count, any_contact, overflow from the
    // lowest bit up, zero padded.
    output logic [ccc_pkg::OUT_TDATA_W-1:0]           m_axis_tdata,
    // Register port.
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [ccc_pkg::CFG_ADDR_W-1:0]       paddr,
    input  wire logic [ccc_pkg::CFG_DATA_W-1:0]       pwdata,
    output logic [ccc_pkg::CFG_DATA_W-1:0]            prdata,
    output logic                                      pready
);

    import ccc_pkg::*;

    localparam int FIELDS_W = 3 * COUNT_W + 2;

    logic [RADIUS_W-1:0] r_cutoff;
    logic                w_reg_sel;
    t_dp_cmd             w_cmd;
    t_dp_status          w_status;
    logic [COUNT_W-1:0]  w_cen_cnt, w_cat_cnt, w_cont_cnt;
    logic                w_any, w_ovf;

    // Register port: one word register, decoded on the word address.
    assign w_reg_sel = (paddr[CFG_ADDR_W-1:2] == REG_CUTOFF_IDX);
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff <= RADIUS_RST;
        end else if (psel && penable && pwrite && pready && w_reg_sel) begin
            r_cutoff <= pwdata[RADIUS_W-1:0];
        end
    end

    assign prdata = w_reg_sel ? CFG_DATA_W'(r_cutoff) : '0;

    ccc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tlast  (s_axis_tlast),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_cmd      (w_cmd),
        .i_status   (w_status)
    );

    ccc_dpath #(
        .MAX_CENTERS (MAX_CENTERS),
        .MAX_CATIONS (MAX_CATIONS),
        .COORD_BITS  (COORD_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_kind          (t_kind'(s_axis_tuser)),
        .i_pos_x         (s_axis_tdata[COORD_BITS-1:0]),
        .i_pos_y         (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_pos_z         (s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .i_cutoff        (r_cutoff),
        .o_center_count  (w_cen_cnt),
        .o_cation_count  (w_cat_cnt),
        .o_contact_count (w_cont_cnt),
        .o_any_contact   (w_any),
        .o_overflow      (w_ovf)
    );

    // Result packing, first field in the lowest bits.
    assign m_axis_tdata = {{(OUT_TDATA_W - FIELDS_W){1'b0}},
                           w_ovf, w_any, w_cont_cnt, w_cat_cnt, w_cen_cnt};

endmodule

`default_nettype wire

// ===== sv/ccc_ram.sv =====
`default_nettype none

module ccc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/ccc_ctrl.sv =====
`default_nettype none
`include "assert_macros.svh"

module ccc_ctrl (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    input  wire logic                   i_s_tlast,
    output logic                        o_s_tready,
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    output ccc_pkg::t_dp_cmd            o_cmd,
    input  wire ccc_pkg::t_dp_status    i_status
);

    import ccc_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        o_m_tvalid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready   = 1'b1;
                o_cmd.accept = i_s_tvalid;
                if (i_s_tvalid && i_s_tlast) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                o_cmd.walk_start = 1'b1;
                n_state = i_status.no_work ? S_FINISH : S_LOAD_CAT;
            end
            S_LOAD_CAT: begin
                o_cmd.cat_rd = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.cen_rd = 1'b1;
                if (i_status.cen_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // Wait until the last pair of this cation has been judged.
                if (!i_status.pipe_busy) begin
                    o_cmd.cat_next = 1'b1;
                    n_state = i_status.cat_last ? S_FINISH : S_LOAD_CAT;
                end
            end
            S_FINISH: begin
                o_cmd.result_load = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                o_m_tvalid = 1'b1;
                if (i_m_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The result must never be latched while a distance test is in flight.
    `CCC_ASSERT(a_load_after_drain, i_clk, i_rst_n, o_cmd.result_load |-> !i_status.pipe_busy)
    // A center read is only issued when there is something to compare.
    `CCC_ASSERT(a_scan_has_work, i_clk, i_rst_n, o_cmd.cen_rd |-> !i_status.no_work)

endmodule

`default_nettype wire

// ===== sv/ccc_dpath.sv =====
`default_nettype none
`include "assert_macros.svh"

module ccc_dpath #(
    parameter int MAX_CENTERS = ccc_pkg::MAX_CENTERS_DEF,
    parameter int MAX_CATIONS = ccc_pkg::MAX_CATIONS_DEF,
    parameter int COORD_BITS  = ccc_pkg::COORD_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire ccc_pkg::t_dp_cmd               i_cmd,
    output ccc_pkg::t_dp_status                 o_status,
    input  wire ccc_pkg::t_kind                 i_kind,
    input  wire logic signed [COORD_BITS-1:0]   i_pos_x,
    input  wire logic signed [COORD_BITS-1:0]   i_pos_y,
    input  wire logic signed [COORD_BITS-1:0]   i_pos_z,
    input  wire logic [ccc_pkg::RADIUS_W-1:0]   i_cutoff,
    output logic [ccc_pkg::COUNT_W-1:0]         o_center_count,
    output logic [ccc_pkg::COUNT_W-1:0]         o_cation_count,
    output logic [ccc_pkg::COUNT_W-1:0]         o_contact_count,
    output logic                                o_any_contact,
    output logic                                o_overflow
);

    import ccc_pkg::*;

    localparam int CEN_AW = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
    localparam int CAT_AW = (MAX_CATIONS > 1) ? $clog2(MAX_CATIONS) : 1;
    localparam int CEN_CW = $clog2(MAX_CENTERS + 1);
    localparam int CAT_CW = $clog2(MAX_CATIONS + 1);
    localparam int SUM_CB = COORD_BITS + 1;
    localparam int D_W    = COORD_BITS + 2;
    localparam int CMP_W  = (D_W > LIM_W) ? D_W : LIM_W;
    localparam int CEN_DW = 3 * SUM_CB;
    localparam int CAT_DW = 3 * COORD_BITS;

    // Per data set state.
    logic signed [COORD_BITS-1:0] r_pend_x, r_pend_y, r_pend_z;
    logic [CEN_CW-1:0] r_ncen;
    logic [CAT_CW-1:0] r_ncat;
    logic              r_dropped;

    // Walk state.
    logic [CAT_CW-1:0] r_ci;
    logic [CEN_CW-1:0] r_ki;
    logic [CAT_CW-1:0] r_contacts;
    logic              r_any_hit;
    logic              r_v0, r_v1, r_v2;

    // Distance pipeline payload.
    logic [LIM_W-1:0] r_abs [3];
    logic [SQ_W-1:0]  r_sq  [3];
    logic             r_ok1, r_ok2;
    logic [SQ_W-1:0]  r_thr;

    // Result registers.
    logic [COUNT_W-1:0] r_res_cen, r_res_cat, r_res_cont;
    logic               r_res_any, r_res_ovf;

    logic                     w_cen_we, w_cat_we;
    logic signed [SUM_CB-1:0] w_sum_x, w_sum_y, w_sum_z;
    logic [CEN_DW-1:0]        w_cen_wdata, w_cen_q;
    logic [CAT_DW-1:0]        w_cat_wdata, w_cat_q;
    logic [LIM_W-1:0]         w_lim2;
    logic signed [COORD_BITS-1:0] w_cat [3];
    logic signed [SUM_CB-1:0] w_cx2 [3];
    logic signed [SUM_CB-1:0] w_csum [3];
    logic signed [D_W-1:0]    w_d [3];
    logic [D_W-1:0]           w_mag [3];
    logic [2:0]               w_axis_ok;
    logic [SUM_W-1:0]         w_dist;

    // Store writes for ring ends and cations.
    assign w_cen_we = i_cmd.accept && (i_kind == KIND_END) &&
                      (r_ncen < CEN_CW'(MAX_CENTERS));
    assign w_cat_we = i_cmd.accept && (i_kind == KIND_CATION) &&
                      (r_ncat < CAT_CW'(MAX_CATIONS));

    assign w_sum_x = SUM_CB'(i_pos_x) + SUM_CB'(r_pend_x);
    assign w_sum_y = SUM_CB'(i_pos_y) + SUM_CB'(r_pend_y);
    assign w_sum_z = SUM_CB'(i_pos_z) + SUM_CB'(r_pend_z);

    assign w_cen_wdata = {w_sum_z, w_sum_y, w_sum_x};
    assign w_cat_wdata = {i_pos_z, i_pos_y, i_pos_x};

    ccc_ram #(
        .WIDTH (CEN_DW),
        .DEPTH (MAX_CENTERS)
    ) u_cen_ram (
        .i_clk   (i_clk),
        .i_we    (w_cen_we),
        .i_waddr (r_ncen[CEN_AW-1:0]),
        .i_wdata (w_cen_wdata),
        .i_re    (i_cmd.cen_rd),
        .i_raddr (r_ki[CEN_AW-1:0]),
        .o_rdata (w_cen_q)
    );

    ccc_ram #(
        .WIDTH (CAT_DW),
        .DEPTH (MAX_CATIONS)
    ) u_cat_ram (
        .i_clk   (i_clk),
        .i_we    (w_cat_we),
        .i_waddr (r_ncat[CAT_AW-1:0]),
        .i_wdata (w_cat_wdata),
        .i_re    (i_cmd.cat_rd),
        .i_raddr (r_ci[CAT_AW-1:0]),
        .o_rdata (w_cat_q)
    );

    // Stage one: axis differences on doubled coordinates and the per-axis bound.
    assign w_lim2 = {i_cutoff, 1'b0};

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_cat[a]     = w_cat_q[a*COORD_BITS +: COORD_BITS];
            w_csum[a]    = w_cen_q[a*SUM_CB +: SUM_CB];
            w_cx2[a]     = {w_cat[a], 1'b0};
            w_d[a]       = D_W'(w_cx2[a]) - D_W'(w_csum[a]);
            w_mag[a]     = w_d[a][D_W-1] ? unsigned'(-w_d[a]) : unsigned'(w_d[a]);
            w_axis_ok[a] = CMP_W'(w_mag[a]) <= CMP_W'(w_lim2);
        end
    end

    // Stage three: sum of squares against the squared limit.
    assign w_dist = SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);

    // Pipeline payload and results.
    always_ff @(posedge i_clk) begin
        r_thr <= w_lim2 * w_lim2;
        r_ok1 <= &w_axis_ok;
        r_ok2 <= r_ok1;
        for (int a = 0; a < 3; a++) begin
            r_abs[a] <= LIM_W'(w_mag[a]);
            r_sq[a]  <= r_abs[a] * r_abs[a];
        end
        if (i_cmd.result_load) begin
            r_res_cen  <= COUNT_W'(r_ncen);
            r_res_cat  <= COUNT_W'(r_ncat);
            r_res_cont <= COUNT_W'(r_contacts);
            r_res_any  <= (r_contacts != '0);
            r_res_ovf  <= r_dropped;
        end
    end

    // Control state of the stores and the walk.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_x   <= '0;
            r_pend_y   <= '0;
            r_pend_z   <= '0;
            r_ncen     <= '0;
            r_ncat     <= '0;
            r_dropped  <= 1'b0;
            r_ci       <= '0;
            r_ki       <= '0;
            r_contacts <= '0;
            r_any_hit  <= 1'b0;
            r_v0       <= 1'b0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
        end else begin
            r_v0 <= i_cmd.cen_rd;
            r_v1 <= r_v0;
            r_v2 <= r_v1;

            // Record intake.
            if (i_cmd.accept) begin
                case (i_kind)
                    KIND_START: begin
                        r_pend_x <= i_pos_x;
                        r_pend_y <= i_pos_y;
                        r_pend_z <= i_pos_z;
                    end
                    KIND_END: begin
                        if (w_cen_we) begin
                            r_ncen <= r_ncen + 1'b1;
                        end else begin
                            r_dropped <= 1'b1;
                        end
                    end
                    KIND_CATION: begin
                        if (w_cat_we) begin
                            r_ncat <= r_ncat + 1'b1;
                        end else begin
                            r_dropped <= 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            // Walk over cations and centers.
            if (i_cmd.walk_start) begin
                r_ci       <= '0;
                r_contacts <= '0;
            end
            if (i_cmd.cat_rd) begin
                r_ki      <= '0;
                r_any_hit <= 1'b0;
            end
            if (i_cmd.cen_rd) begin
                r_ki <= r_ki + 1'b1;
            end
            if (r_v2 && r_ok2 && (w_dist <= SUM_W'(r_thr))) begin
                r_any_hit <= 1'b1;
            end
            if (i_cmd.cat_next) begin
                r_ci       <= r_ci + 1'b1;
                r_contacts <= r_contacts + CAT_CW'(r_any_hit);
            end

            // Clear the data set once its result is latched.
            if (i_cmd.result_load) begin
                r_pend_x   <= '0;
                r_pend_y   <= '0;
                r_pend_z   <= '0;
                r_ncen     <= '0;
                r_ncat     <= '0;
                r_dropped  <= 1'b0;
                r_contacts <= '0;
            end
        end
    end

    // Status toward the controller.
    assign o_status.no_work   = (r_ncat == '0) || (r_ncen == '0);
    assign o_status.cat_last  = (CAT_CW'(r_ci + 1'b1) == r_ncat);
    assign o_status.cen_last  = (CEN_CW'(r_ki + 1'b1) == r_ncen);
    assign o_status.pipe_busy = r_v0 | r_v1 | r_v2;

    assign o_center_count  = r_res_cen;
    assign o_cation_count  = r_res_cat;
    assign o_contact_count = r_res_cont;
    assign o_any_contact   = r_res_any;
    assign o_overflow      = r_res_ovf;

    // Each cation is counted at most once.
    `CCC_ASSERT(a_contacts_bounded, i_clk, i_rst_n, r_contacts <= r_ncat)
    // Center reads stay below the number of stored centers.
    `CCC_ASSERT(a_cen_rd_range, i_clk, i_rst_n, i_cmd.cen_rd |-> (r_ki < r_ncen))
    // A ring end that meets a full store raises the drop flag.
    `CCC_ASSERT_NEXT(a_drop_flag, i_clk, i_rst_n, i_cmd.accept && (i_kind == KIND_END) && (r_ncen == CEN_CW'(MAX_CENTERS)), r_dropped)

endmodule

`default_nettype wire
